>>> rtl/mscs_pkg.sv
`default_nettype none

package mscs_pkg;

    // grid limits and field widths
    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int COORD_BITS  = 8;
    localparam int COUNT_BITS  = 9;
    localparam int INDEX_BITS  = 17;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    // register map, word index = paddr[3:2]
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_COLUMNS   = 2'd1;
    localparam logic [1:0] REG_ROWS      = 2'd2;

    // one grid cell: top-left vertex and four corner samples
    typedef struct packed {
        logic [COORD_BITS-1:0]         cell_x;
        logic [COORD_BITS-1:0]         cell_y;
        logic signed [SAMPLE_BITS-1:0] top_left;
        logic signed [SAMPLE_BITS-1:0] top_right;
        logic signed [SAMPLE_BITS-1:0] bottom_right;
        logic signed [SAMPLE_BITS-1:0] bottom_left;
    } cell_t;

    // one output segment
    typedef struct packed {
        logic                  first_is_vertex;
        logic [INDEX_BITS-1:0] first_index;
        logic                  second_is_vertex;
        logic [INDEX_BITS-1:0] second_index;
        logic                  last_of_cell;
    } segment_t;

    // segment endpoint: vertex flag plus index
    typedef struct packed {
        logic                  is_vertex;
        logic [INDEX_BITS-1:0] index;
    } endpoint_t;

    // everything one cell yields
    typedef struct packed {
        logic [1:0] count;
        segment_t   first;
        segment_t   second;
    } seg_pair_t;

endpackage

`default_nettype wire

>>> rtl/mscs_seg_calc.sv
`default_nettype none

module mscs_seg_calc (
    input  wire logic [mscs_pkg::COUNT_BITS-1:0]         cols,
    input  wire logic [mscs_pkg::COUNT_BITS-1:0]         rows,
    input  wire logic signed [mscs_pkg::SAMPLE_BITS-1:0] threshold,
    input  wire mscs_pkg::cell_t                         cell_word,
    output mscs_pkg::seg_pair_t                          pair
);

    localparam int IW = mscs_pkg::INDEX_BITS;
    localparam int SW = mscs_pkg::SAMPLE_BITS;

    // case codes: bit 3 top-left, 2 top-right, 1 bottom-right, 0 bottom-left
    localparam logic [3:0] CODE_BL      = 4'd1;
    localparam logic [3:0] CODE_BR      = 4'd2;
    localparam logic [3:0] CODE_BR_BL   = 4'd3;
    localparam logic [3:0] CODE_TR      = 4'd4;
    localparam logic [3:0] SADDLE_TR_BL = 4'd5;
    localparam logic [3:0] CODE_TR_BR   = 4'd6;
    localparam logic [3:0] CODE_NOT_TL  = 4'd7;
    localparam logic [3:0] CODE_TL      = 4'd8;
    localparam logic [3:0] CODE_TL_BL   = 4'd9;
    localparam logic [3:0] SADDLE_TL_BR = 4'd10;
    localparam logic [3:0] CODE_NOT_TR  = 4'd11;
    localparam logic [3:0] CODE_TL_TR   = 4'd12;
    localparam logic [3:0] CODE_NOT_BR  = 4'd13;
    localparam logic [3:0] CODE_NOT_BL  = 4'd14;

    // edge endpoint, snapped to a vertex when exactly one end sits on the level
    function automatic mscs_pkg::endpoint_t edge_key(
        input logic [IW-1:0] edge_idx,
        input logic          a_on,
        input logic          b_on,
        input logic [IW-1:0] va,
        input logic [IW-1:0] vb
    );
        mscs_pkg::endpoint_t k;
        k.is_vertex = a_on ^ b_on;
        if (a_on && !b_on)
            k.index = va;
        else if (b_on && !a_on)
            k.index = vb;
        else
            k.index = edge_idx;
        return k;
    endfunction

    function automatic mscs_pkg::segment_t make_seg(
        input mscs_pkg::endpoint_t p,
        input mscs_pkg::endpoint_t q,
        input logic                last
    );
        mscs_pkg::segment_t s;
        s.first_is_vertex  = p.is_vertex;
        s.first_index      = p.index;
        s.second_is_vertex = q.is_vertex;
        s.second_index     = q.index;
        s.last_of_cell     = last;
        return s;
    endfunction

    logic [9:0]          x_end;
    logic [9:0]          y_end;
    logic                in_grid;
    logic [3:0]          code;
    logic [7:0]          cols_m1;
    logic [IW-1:0]       horiz;
    logic [IW-1:0]       vtl;
    logic [IW-1:0]       vtr;
    logic [IW-1:0]       vbl;
    logic [IW-1:0]       vbr;
    logic [IW-1:0]       h_top;
    logic [IW-1:0]       h_bot;
    logic                on_tl;
    logic                on_tr;
    logic                on_br;
    logic                on_bl;
    logic signed [SW+1:0] corner_sum;
    logic signed [SW+1:0] thr4;
    logic                high;
    mscs_pkg::endpoint_t top_ep;
    mscs_pkg::endpoint_t right_ep;
    mscs_pkg::endpoint_t bottom_ep;
    mscs_pkg::endpoint_t left_ep;

    // cell must fit inside the grid
    assign x_end   = {2'b00, cell_word.cell_x} + 10'd2;
    assign y_end   = {2'b00, cell_word.cell_y} + 10'd2;
    assign in_grid = (x_end <= {1'b0, cols}) && (y_end <= {1'b0, rows});

    assign code = {cell_word.top_left >= threshold, cell_word.top_right >= threshold,
                   cell_word.bottom_right >= threshold,
                   cell_word.bottom_left >= threshold};

    // vertex and edge indices
    assign cols_m1 = 8'(cols - 9'd1);
    assign horiz   = IW'(rows) * IW'(cols_m1);
    assign vtl     = IW'(cell_word.cell_y) * IW'(cols) + IW'(cell_word.cell_x);
    assign vtr     = vtl + IW'(1);
    assign vbl     = vtl + IW'(cols);
    assign vbr     = vbl + IW'(1);
    assign h_top   = IW'(cell_word.cell_y) * IW'(cols_m1) + IW'(cell_word.cell_x);
    assign h_bot   = h_top + IW'(cols_m1);

    assign on_tl = cell_word.top_left == threshold;
    assign on_tr = cell_word.top_right == threshold;
    assign on_br = cell_word.bottom_right == threshold;
    assign on_bl = cell_word.bottom_left == threshold;

    assign top_ep    = edge_key(h_top, on_tl, on_tr, vtl, vtr);
    assign right_ep  = edge_key(horiz + vtr, on_tr, on_br, vtr, vbr);
    assign bottom_ep = edge_key(h_bot, on_bl, on_br, vbl, vbr);
    assign left_ep   = edge_key(horiz + vtl, on_tl, on_bl, vtl, vbl);

    // saddle decision: exact corner sum against four times the level
    assign corner_sum = (SW+2)'(cell_word.top_left) + (SW+2)'(cell_word.top_right)
                      + (SW+2)'(cell_word.bottom_right) + (SW+2)'(cell_word.bottom_left);
    assign thr4       = {threshold, 2'b00};
    assign high       = corner_sum >= thr4;

    // segment table
    always_comb
    begin
        pair.count  = 2'd1;
        pair.first  = make_seg(left_ep, bottom_ep, 1'b1);
        pair.second = make_seg(top_ep, right_ep, 1'b1);
        case (code) inside
            CODE_BL, CODE_NOT_BL:
            begin
                pair.first = make_seg(left_ep, bottom_ep, 1'b1);
            end
            CODE_BR, CODE_NOT_BR:
            begin
                pair.first = make_seg(bottom_ep, right_ep, 1'b1);
            end
            CODE_BR_BL, CODE_TL_TR:
            begin
                pair.first = make_seg(left_ep, right_ep, 1'b1);
            end
            CODE_TR, CODE_NOT_TR:
            begin
                pair.first = make_seg(top_ep, right_ep, 1'b1);
            end
            CODE_TR_BR, CODE_TL_BL:
            begin
                pair.first = make_seg(top_ep, bottom_ep, 1'b1);
            end
            CODE_NOT_TL, CODE_TL:
            begin
                pair.first = make_seg(left_ep, top_ep, 1'b1);
            end
            SADDLE_TR_BL, SADDLE_TL_BR:
            begin
                pair.count = 2'd2;
                if (high == (code == SADDLE_TR_BL))
                begin
                    pair.first  = make_seg(left_ep, top_ep, 1'b0);
                    pair.second = make_seg(bottom_ep, right_ep, 1'b1);
                end
                else
                begin
                    pair.first  = make_seg(left_ep, bottom_ep, 1'b0);
                    pair.second = make_seg(top_ep, right_ep, 1'b1);
                end
            end
            default:
            begin
                // all corners on one side
                pair.count = 2'd0;
            end
        endcase
        if (!in_grid)
            pair.count = 2'd0;
    end

endmodule

`default_nettype wire

>>> rtl/marching_squares_cell_segments.sv
`default_nettype none

// Channel  Dir  Word                    Handshake
// cell     in   mscs_pkg::cell_t        cell_valid / cell_stall
// seg      out  mscs_pkg::segment_t     seg_valid / seg_stall
// config   in   APB, 3 x 32-bit regs    psel / penable / pready
//
// A cell is registered, decoded combinationally and its first segment lands in the
// output register, which drives seg_valid.
// One cell per cycle when each gives at most one segment and the output is not
// stalled; a saddle cell holds its second segment in a spare register and a
// following cell that gives a segment waits until the spare has moved out.
// Reset clears all valids and loads threshold 0, 256 columns, 256 rows.
// A stalled output holds its word; the input keeps flowing while the output
// register can still take the next segment.

module marching_squares_cell_segments (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cell_valid,
    output logic                                 cell_stall,
    input  wire mscs_pkg::cell_t                 cell_word,
    output logic                                 seg_valid,
    input  wire logic                            seg_stall,
    output mscs_pkg::segment_t                   seg,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mscs_pkg::ADDR_BITS-1:0]  paddr,
    input  wire logic [mscs_pkg::DATA_BITS-1:0]  pwdata,
    output logic [mscs_pkg::DATA_BITS-1:0]       prdata,
    output logic                                 pready
);

    localparam int CW = mscs_pkg::COUNT_BITS;
    localparam int SW = mscs_pkg::SAMPLE_BITS;

    function automatic logic [CW-1:0] clamp_count(
        input logic [CW-1:0] v,
        input logic [CW-1:0] maxv
    );
        logic [CW-1:0] r;
        if (v < CW'(2))
            r = CW'(2);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    logic signed [SW-1:0] thr_reg;
    logic [CW-1:0]        cols_raw_reg;
    logic [CW-1:0]        rows_raw_reg;
    logic [CW-1:0]        cols_reg;
    logic [CW-1:0]        rows_reg;
    logic                 cfg_wr;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    mscs_pkg::cell_t      s1_cell_reg;
    mscs_pkg::seg_pair_t  pair;
    logic                 in_take;
    logic                 out_free;
    logic                 s1_move;

    logic                 seg_valid_reg;
    logic                 seg_valid_next;
    mscs_pkg::segment_t   seg_reg;
    mscs_pkg::segment_t   seg_next;
    logic                 spare_valid_reg;
    logic                 spare_valid_next;
    mscs_pkg::segment_t   spare_reg;
    mscs_pkg::segment_t   spare_next;

    // config registers, clamped grid size kept alongside the raw value
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= '0;
            cols_raw_reg <= CW'(mscs_pkg::MAX_COLUMNS);
            rows_raw_reg <= CW'(mscs_pkg::MAX_ROWS);
            cols_reg     <= CW'(mscs_pkg::MAX_COLUMNS);
            rows_reg     <= CW'(mscs_pkg::MAX_ROWS);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                mscs_pkg::REG_THRESHOLD:
                begin
                    thr_reg <= pwdata[SW-1:0];
                end
                mscs_pkg::REG_COLUMNS:
                begin
                    cols_raw_reg <= pwdata[CW-1:0];
                    cols_reg     <= clamp_count(pwdata[CW-1:0],
                                                CW'(mscs_pkg::MAX_COLUMNS));
                end
                mscs_pkg::REG_ROWS:
                begin
                    rows_raw_reg <= pwdata[CW-1:0];
                    rows_reg     <= clamp_count(pwdata[CW-1:0],
                                                CW'(mscs_pkg::MAX_ROWS));
                end
                default:
                begin
                    // unmapped address
                end
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (paddr[3:2])
            mscs_pkg::REG_THRESHOLD: prdata = mscs_pkg::DATA_BITS'(unsigned'(thr_reg));
            mscs_pkg::REG_COLUMNS:   prdata = mscs_pkg::DATA_BITS'(cols_raw_reg);
            mscs_pkg::REG_ROWS:      prdata = mscs_pkg::DATA_BITS'(rows_raw_reg);
            default:                 prdata = '0;
        endcase
    end

    // segment decode on the registered cell
    mscs_seg_calc u_calc (
        .cols      (cols_reg),
        .rows      (rows_reg),
        .threshold (thr_reg),
        .cell_word (s1_cell_reg),
        .pair      (pair)
    );

    // flow control
    assign out_free   = !seg_valid_reg || !seg_stall;
    assign s1_move    = s1_valid_reg &&
                        ((pair.count == 2'd0) || (!spare_valid_reg && out_free));
    assign cell_stall = s1_valid_reg && !s1_move;
    assign in_take    = cell_valid && !cell_stall;

    assign s1_valid_next = in_take || (s1_valid_reg && !s1_move);

    // output register and spare for the second saddle segment
    always_comb
    begin
        seg_valid_next   = seg_valid_reg;
        seg_next         = seg_reg;
        spare_valid_next = spare_valid_reg;
        spare_next       = spare_reg;
        if (spare_valid_reg && out_free)
        begin
            seg_valid_next   = 1'b1;
            seg_next         = spare_reg;
            spare_valid_next = 1'b0;
        end
        else if (s1_move && (pair.count != 2'd0))
        begin
            seg_valid_next = 1'b1;
            seg_next       = pair.first;
            if (pair.count == 2'd2)
            begin
                spare_valid_next = 1'b1;
                spare_next       = pair.second;
            end
        end
        else if (out_free)
        begin
            seg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            seg_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            seg_valid_reg   <= seg_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_cell_reg <= cell_word;
        seg_reg   <= seg_next;
        spare_reg <= spare_next;
    end

    assign seg_valid = seg_valid_reg;
    assign seg       = seg_reg;

endmodule

`default_nettype wire

>>> dv/marching_squares_cell_segments_tb.sv
`default_nettype none

module marching_squares_cell_segments_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF         = 5;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int PHASE_CELLS      = 60;

    // case codes, bit order top-left, top-right, bottom-right, bottom-left
    localparam logic [3:0] CASE_NONE        = 4'd0;
    localparam logic [3:0] CASE_ALL         = 4'd15;
    localparam logic [3:0] CUT_BOTTOM_LEFT  = 4'd1;
    localparam logic [3:0] CUT_BOTTOM_RIGHT = 4'd2;
    localparam logic [3:0] CUT_HORIZONTAL   = 4'd3;
    localparam logic [3:0] CUT_TOP_RIGHT    = 4'd4;
    localparam logic [3:0] SADDLE_TR_BL     = 4'd5;
    localparam logic [3:0] CUT_VERTICAL     = 4'd6;
    localparam logic [3:0] CUT_TOP_LEFT     = 4'd7;
    localparam logic [3:0] SADDLE_TL_BR     = 4'd10;

    // directed stimulus row; typed_count < 0 means use the predictor
    typedef struct {
        mscs_pkg::cell_t    cell_word;
        int                 typed_count;
        mscs_pkg::segment_t typed_seg;
    } cell_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cell_valid;
    logic                           cell_stall;
    mscs_pkg::cell_t                cell_word;
    logic                           seg_valid;
    logic                           seg_stall;
    mscs_pkg::segment_t             seg;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [mscs_pkg::ADDR_BITS-1:0] paddr;
    logic [mscs_pkg::DATA_BITS-1:0] pwdata;
    logic [mscs_pkg::DATA_BITS-1:0] prdata;
    logic                           pready;

    // shadow copy of the config registers
    logic signed [mscs_pkg::SAMPLE_BITS-1:0] level;
    logic [mscs_pkg::COUNT_BITS-1:0]         grid_cols;
    logic [mscs_pkg::COUNT_BITS-1:0]         grid_rows;

    mscs_pkg::segment_t pending_segs[$];
    cell_row_t          cell_rows[$];
    int                 mismatch_count;
    bit                 idle_on;
    bit                 long_hold_pending;
    int                 calm_left;

    marching_squares_cell_segments u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .cell_word  (cell_word),
        .seg_valid  (seg_valid),
        .seg_stall  (seg_stall),
        .seg        (seg),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // run limit
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    function automatic int clamp_count(input logic [mscs_pkg::COUNT_BITS-1:0] v,
                                       input int maxv);
        if (v < 2)
            return 2;
        if (v > maxv)
            return maxv;
        return int'(v);
    endfunction

    // endpoint of a crossed edge, snapped to a vertex when exactly one end sits on the level
    function automatic mscs_pkg::endpoint_t edge_end(input int edge_id, input int a,
                                                     input int b, input int va,
                                                     input int vb, input int thr);
        mscs_pkg::endpoint_t e;
        e.is_vertex = 1'b0;
        e.index     = edge_id[mscs_pkg::INDEX_BITS-1:0];
        if (a == thr && b != thr)
        begin
            e.is_vertex = 1'b1;
            e.index     = va[mscs_pkg::INDEX_BITS-1:0];
        end
        else if (b == thr && a != thr)
        begin
            e.is_vertex = 1'b1;
            e.index     = vb[mscs_pkg::INDEX_BITS-1:0];
        end
        return e;
    endfunction

    function automatic mscs_pkg::segment_t make_seg(input mscs_pkg::endpoint_t p,
                                                    input mscs_pkg::endpoint_t q,
                                                    input logic last);
        return '{p.is_vertex, p.index, q.is_vertex, q.index, last};
    endfunction

    // expected segments of one accepted cell
    function automatic void predict_segments(input mscs_pkg::cell_t c);
        int                  cols, rows, thr, tl, tr, br, bl, x, y;
        int                  horiz, vtl, vtr, vbl, vbr;
        logic [3:0]          code;
        logic [3:0]          fold;
        logic                high;
        mscs_pkg::endpoint_t top_e, right_e, bottom_e, left_e, p, q;
        cols = clamp_count(grid_cols, mscs_pkg::MAX_COLUMNS);
        rows = clamp_count(grid_rows, mscs_pkg::MAX_ROWS);
        x    = int'(c.cell_x);
        y    = int'(c.cell_y);
        thr  = int'(level);
        tl   = int'(c.top_left);
        tr   = int'(c.top_right);
        br   = int'(c.bottom_right);
        bl   = int'(c.bottom_left);
        // cell must lie inside the grid
        if (x + 2 > cols || y + 2 > rows)
            return;
        code = {tl >= thr, tr >= thr, br >= thr, bl >= thr};
        if (code == CASE_NONE || code == CASE_ALL)
            return;
        horiz    = rows * (cols - 1);
        vtl      = y * cols + x;
        vtr      = vtl + 1;
        vbl      = vtl + cols;
        vbr      = vbl + 1;
        top_e    = edge_end(y * (cols - 1) + x, tl, tr, vtl, vtr, thr);
        right_e  = edge_end(horiz + y * cols + x + 1, tr, br, vtr, vbr, thr);
        bottom_e = edge_end((y + 1) * (cols - 1) + x, bl, br, vbl, vbr, thr);
        left_e   = edge_end(horiz + y * cols + x, tl, bl, vtl, vbl, thr);
        high     = (tl + tr + br + bl) >= 4 * thr;
        // saddles: corner sum picks which pair of corners is joined
        if (code == SADDLE_TR_BL || code == SADDLE_TL_BR)
        begin
            if ((code == SADDLE_TR_BL) == high)
            begin
                pending_segs.push_back(make_seg(left_e, top_e, 1'b0));
                pending_segs.push_back(make_seg(bottom_e, right_e, 1'b1));
            end
            else
            begin
                pending_segs.push_back(make_seg(left_e, bottom_e, 1'b0));
                pending_segs.push_back(make_seg(top_e, right_e, 1'b1));
            end
            return;
        end
        // complementary codes cut the same edges
        fold = code[3] ? ~code : code;
        p = left_e;
        q = top_e;
        case (fold)
            CUT_BOTTOM_LEFT:  begin p = left_e;   q = bottom_e; end
            CUT_BOTTOM_RIGHT: begin p = bottom_e; q = right_e;  end
            CUT_HORIZONTAL:   begin p = left_e;   q = right_e;  end
            CUT_TOP_RIGHT:    begin p = top_e;    q = right_e;  end
            CUT_VERTICAL:     begin p = top_e;    q = bottom_e; end
            CUT_TOP_LEFT:     begin p = left_e;   q = top_e;    end
            default:          begin p = left_e;   q = top_e;    end
        endcase
        pending_segs.push_back(make_seg(p, q, 1'b1));
    endfunction

    // APB write: setup, access, then idle
    task automatic write_reg(input logic [1:0] idx,
                             input logic [mscs_pkg::DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            mscs_pkg::REG_THRESHOLD: level     = value[mscs_pkg::SAMPLE_BITS-1:0];
            mscs_pkg::REG_COLUMNS:   grid_cols = value[mscs_pkg::COUNT_BITS-1:0];
            mscs_pkg::REG_ROWS:      grid_rows = value[mscs_pkg::COUNT_BITS-1:0];
            default:                 ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_grid(input int thr, input int cols, input int rows);
        logic [mscs_pkg::SAMPLE_BITS-1:0] t;
        t = thr[mscs_pkg::SAMPLE_BITS-1:0];
        write_reg(mscs_pkg::REG_THRESHOLD,
                  {{(mscs_pkg::DATA_BITS-mscs_pkg::SAMPLE_BITS){t[mscs_pkg::SAMPLE_BITS-1]}},
                   t});
        write_reg(mscs_pkg::REG_COLUMNS,
                  mscs_pkg::DATA_BITS'(cols[mscs_pkg::COUNT_BITS-1:0]));
        write_reg(mscs_pkg::REG_ROWS,
                  mscs_pkg::DATA_BITS'(rows[mscs_pkg::COUNT_BITS-1:0]));
    endtask

    // offer one cell word after an optional gap, return once accepted
    task automatic send_cell(input mscs_pkg::cell_t c, input int gap);
        if (gap > 0)
        begin
            cell_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_word  <= c;
        @(posedge clk);
        while (cell_stall)
            @(posedge clk);
    endtask

    // stop offering, wait for every expected segment, then let the pipe empty
    task automatic drain_and_settle();
        cell_valid <= 1'b0;
        while (pending_segs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_gap();
        if (!idle_on)
            return 0;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = 30;
            return 0;
        end
        return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 13)) : 0;
    endfunction

    // samples cluster around the level so most cells are cut
    function automatic logic signed [mscs_pkg::SAMPLE_BITS-1:0] rand_sample(input int thr);
        int v;
        case ($urandom_range(0, 5))
            0, 1:    v = thr + int'($urandom_range(0, 6)) - 3;
            2:       v = thr;
            3:       v = ($urandom_range(0, 1) == 0) ? -32768 : 32767;
            default: v = int'($signed(mscs_pkg::SAMPLE_BITS'($urandom())));
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[mscs_pkg::SAMPLE_BITS-1:0];
    endfunction

    function automatic mscs_pkg::cell_t rand_cell();
        mscs_pkg::cell_t c;
        int              cols, rows;
        cols = clamp_count(grid_cols, mscs_pkg::MAX_COLUMNS);
        rows = clamp_count(grid_rows, mscs_pkg::MAX_ROWS);
        // mostly inside the grid, some anywhere
        c.cell_x = ($urandom_range(0, 9) == 0)
                 ? mscs_pkg::COORD_BITS'($urandom_range(0, 255))
                 : mscs_pkg::COORD_BITS'($urandom_range(0, cols - 2));
        c.cell_y = ($urandom_range(0, 9) == 0)
                 ? mscs_pkg::COORD_BITS'($urandom_range(0, 255))
                 : mscs_pkg::COORD_BITS'($urandom_range(0, rows - 2));
        c.top_left     = rand_sample(int'(level));
        c.top_right    = rand_sample(int'(level));
        c.bottom_right = rand_sample(int'(level));
        c.bottom_left  = rand_sample(int'(level));
        return c;
    endfunction

    function automatic void add_row(input int x, input int y, input int tl, input int tr,
                                    input int br, input int bl, input int n,
                                    input mscs_pkg::segment_t s);
        cell_row_t r;
        r.cell_word   = '{x[mscs_pkg::COORD_BITS-1:0], y[mscs_pkg::COORD_BITS-1:0],
                          tl[mscs_pkg::SAMPLE_BITS-1:0], tr[mscs_pkg::SAMPLE_BITS-1:0],
                          br[mscs_pkg::SAMPLE_BITS-1:0], bl[mscs_pkg::SAMPLE_BITS-1:0]};
        r.typed_count = n;
        r.typed_seg   = s;
        cell_rows.push_back(r);
    endfunction

    // output checker
    always @(posedge clk)
    begin
        mscs_pkg::segment_t want;
        if (rst_n && seg_valid && !seg_stall)
        begin
            if (pending_segs.size() == 0)
                report_mismatch("segment word with none pending", 1, 0);
            else
            begin
                want = pending_segs.pop_front();
                check_field("first_is_vertex", int'(seg.first_is_vertex),
                            int'(want.first_is_vertex));
                check_field("first_index", int'(seg.first_index),
                            int'(want.first_index));
                check_field("second_is_vertex", int'(seg.second_is_vertex),
                            int'(want.second_is_vertex));
                check_field("second_index", int'(seg.second_index),
                            int'(want.second_index));
                check_field("last_of_cell", int'(seg.last_of_cell),
                            int'(want.last_of_cell));
            end
        end
    end

    // output back-pressure: random bursts, plus one long hold on request
    initial
    begin : seg_stall_gen
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        seg_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                stall_left        = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                seg_stall <= 1'b1;
                stall_left--;
            end
            else if (!idle_on || run_left > 0)
            begin
                seg_stall <= 1'b0;
                if (run_left > 0)
                    run_left--;
            end
            else
            begin
                seg_stall <= 1'b1;
                stall_left = $urandom_range(0, 12);
                run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 20);
            end
        end
    end

    // main sequence
    initial
    begin
        int phase_thr[8];
        int phase_cols[8];
        int phase_rows[8];
        mismatch_count    = 0;
        idle_on           = 1'b1;
        long_hold_pending = 1'b0;
        calm_left         = 0;
        level             = '0;
        grid_cols         = mscs_pkg::COUNT_BITS'(mscs_pkg::MAX_COLUMNS);
        grid_rows         = mscs_pkg::COUNT_BITS'(mscs_pkg::MAX_ROWS);
        rst_n      <= 1'b0;
        cell_valid <= 1'b0;
        cell_word  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cells under the reset settings: level 0, 256 x 256
        add_row(3, 4, -1, -1, -1, -1, 0, '0);                    // all below
        add_row(3, 4, 0, 0, 0, 0, 0, '0);                        // all on level
        add_row(255, 0, 0, -1, -1, -1, 0, '0);                   // right of grid
        add_row(0, 255, 0, -1, -1, -1, 0, '0);                   // below grid
        add_row(0, 0, 0, -1, -1, -1, 1, '{1'b1, 17'd0, 1'b1, 17'd0, 1'b1});
        add_row(254, 254, 32767, -32768, -32768, -32768, 1,
                '{1'b0, 17'd130558, 1'b0, 17'd65024, 1'b1});
        add_row(254, 254, -32768, -32768, 32767, -32768, 1,
                '{1'b0, 17'd65279, 1'b0, 17'd130559, 1'b1});
        add_row(10, 20, -100, -100, -100, 100, -1, '0);
        add_row(10, 20, -100, -100, 100, -100, -1, '0);
        add_row(10, 20, -100, -100, 100, 100, -1, '0);
        add_row(10, 20, -100, 100, -100, -100, -1, '0);
        add_row(10, 20, -100, 100, 100, -100, -1, '0);
        add_row(10, 20, -100, 100, 100, 100, -1, '0);
        add_row(10, 20, 100, -100, -100, 100, -1, '0);
        add_row(10, 20, 100, -100, 100, 100, -1, '0);
        add_row(10, 20, 0, 0, -7, -7, -1, '0);                   // flat top edge
        add_row(10, 20, 100, 100, -100, 100, -1, '0);
        add_row(10, 20, 100, 100, 100, -100, -1, '0);
        add_row(10, 20, -1, 100, -1, 100, -1, '0);               // saddle, high sum
        add_row(10, 20, -100, 1, -100, 1, -1, '0);               // saddle, low sum
        add_row(10, 20, 100, -1, 100, -1, -1, '0);
        add_row(10, 20, 32767, -32768, 32767, -32768, -1, '0);   // saddle at extremes
        add_row(10, 20, -2, 2, -2, 2, -1, '0);                   // sum exactly on level
        add_row(1, 254, 5, -5, 5, 0, -1, '0);

        foreach (cell_rows[i])
        begin
            send_cell(cell_rows[i].cell_word, pick_gap());
            if (cell_rows[i].typed_count < 0)
                predict_segments(cell_rows[i].cell_word);
            else if (cell_rows[i].typed_count > 0)
                pending_segs.push_back(cell_rows[i].typed_seg);
        end
        drain_and_settle();

        // random phases over several grid settings, extremes included
        phase_thr  = '{-32768, 32767, 1, -5, 0, -1234, 0, 100};
        phase_cols = '{2, 511, 0, 17, 0, 256, 3, 256};
        phase_rows = '{2, 300, 1, 9, 0, 3, 256, 256};
        phase_thr[4]  = int'($signed(mscs_pkg::SAMPLE_BITS'($urandom())));
        phase_cols[4] = $urandom_range(2, 256);
        phase_rows[4] = $urandom_range(2, 256);
        for (int ph = 0; ph < 8; ph++)
        begin
            set_grid(phase_thr[ph], phase_cols[ph], phase_rows[ph]);
            // last phase runs at full rate
            if (ph == 7)
                idle_on = 1'b0;
            for (int k = 0; k < PHASE_CELLS; k++)
            begin
                mscs_pkg::cell_t c;
                if (ph == 4 && k == 10)
                    long_hold_pending = 1'b1;
                c = rand_cell();
                send_cell(c, pick_gap());
                predict_segments(c);
            end
            drain_and_settle();
        end

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
